FILE: rtl/hsv_to_rgb_converter_assert.svh
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Clocked assertion with reset disable
`define HSVRGB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion checked in the cycle after the antecedent
`define HSVRGB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

	localparam int HUE_W = 9;
	localparam int CH_W = 8;

	localparam int SECTOR_DEG = 60;
	localparam int FULL = 255;
	localparam int SECTORS = 6;

	// Largest sector index before the wrap by SECTORS
	localparam int MAX_RAW = ((2 ** HUE_W) - 1) / SECTOR_DEG;
	// f = rem * FULL / SECTOR_DEG is exactly rem * FRAC_MUL >> FRAC_SHIFT
	localparam int FRAC_SHIFT = 2;
	localparam int FRAC_MUL = (FULL * (2 ** FRAC_SHIFT)) / SECTOR_DEG;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	// Load enables for the five pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// Exact x / 255 for any product of two 8-bit values
	function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
		logic [2*CH_W:0] sum;
		sum = {1'b0, x} + {{(CH_W+1){1'b0}}, x[2*CH_W-1:CH_W]} + {{(2*CH_W){1'b0}}, 1'b1};
		return sum[2*CH_W-1:CH_W];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/hsvrgb_core.sv
`default_nettype none

module hsvrgb_core (
	input  wire logic                 clk,
	input  wire hsvrgb_pkg::hsv_t      hsv,
	input  wire hsvrgb_pkg::stage_en_t en,
	output hsvrgb_pkg::rgb_t           rgb
);

	localparam int HW = hsvrgb_pkg::HUE_W;
	localparam int CW = hsvrgb_pkg::CH_W;
	localparam int RAW_W = $clog2(hsvrgb_pkg::MAX_RAW + 1);
	localparam int REM_W = $clog2(hsvrgb_pkg::SECTOR_DEG);
	localparam int FM_W = $clog2((hsvrgb_pkg::SECTOR_DEG - 1) * hsvrgb_pkg::FRAC_MUL + 1);

	typedef struct packed {
		hsvrgb_pkg::sector_t sector;
		logic [CW-1:0]       f;
		logic [CW-1:0]       sat;
		logic [CW-1:0]       val;
	} st1_t;

	typedef struct packed {
		hsvrgb_pkg::sector_t sector;
		logic [CW-1:0]       val;
		logic [2*CW-1:0]     fs;
		logic [2*CW-1:0]     nfs;
		logic [2*CW-1:0]     pv;
	} st2_t;

	typedef struct packed {
		hsvrgb_pkg::sector_t sector;
		logic [CW-1:0]       val;
		logic [CW-1:0]       p;
		logic [CW-1:0]       nq;
		logic [CW-1:0]       nt;
	} st3_t;

	typedef struct packed {
		hsvrgb_pkg::sector_t sector;
		logic [CW-1:0]       val;
		logic [CW-1:0]       p;
		logic [2*CW-1:0]     qv;
		logic [2*CW-1:0]     tv;
	} st4_t;

	st1_t d_s1;
	st2_t d_s2;
	st3_t d_s3;
	st4_t d_s4;
	hsvrgb_pkg::rgb_t rgb_s5;

	logic [RAW_W-1:0] raw;
	logic [HW-1:0]    base;
	logic [REM_W-1:0] rem;
	logic [FM_W-1:0]  frac_mul;
	logic [CW-1:0]    q;
	logic [CW-1:0]    t;
	hsvrgb_pkg::rgb_t rgb_sel;

	// Split hue into sector and position within the sector
	always_comb begin
		raw = '0;
		for (int i = 1; i <= hsvrgb_pkg::MAX_RAW; i++) begin
			if (hsv.hue >= HW'(i * hsvrgb_pkg::SECTOR_DEG)) begin
				raw = RAW_W'(i);
			end
		end
		base = HW'(raw) * HW'(hsvrgb_pkg::SECTOR_DEG);
		rem = REM_W'(hsv.hue - base);
		frac_mul = FM_W'(rem) * FM_W'(hsvrgb_pkg::FRAC_MUL);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			d_s1.sector <= (raw >= RAW_W'(hsvrgb_pkg::SECTORS))
				? hsvrgb_pkg::sector_t'(3'(raw - RAW_W'(hsvrgb_pkg::SECTORS)))
				: hsvrgb_pkg::sector_t'(3'(raw));
			d_s1.f <= CW'(frac_mul >> hsvrgb_pkg::FRAC_SHIFT);
			d_s1.sat <= hsv.saturation;
			d_s1.val <= hsv.brightness;
		end
	end

	// Scale fraction and complement by saturation
	always_ff @(posedge clk) begin
		if (en.s2) begin
			d_s2.sector <= d_s1.sector;
			d_s2.val <= d_s1.val;
			d_s2.fs <= d_s1.f * d_s1.sat;
			d_s2.nfs <= (CW'(hsvrgb_pkg::FULL) - d_s1.f) * d_s1.sat;
			d_s2.pv <= (CW'(hsvrgb_pkg::FULL) - d_s1.sat) * d_s1.val;
		end
	end

	// Divide by full scale, form the q and t factors
	always_ff @(posedge clk) begin
		if (en.s3) begin
			d_s3.sector <= d_s2.sector;
			d_s3.val <= d_s2.val;
			d_s3.p <= hsvrgb_pkg::div255(d_s2.pv);
			d_s3.nq <= CW'(hsvrgb_pkg::FULL) - hsvrgb_pkg::div255(d_s2.fs);
			d_s3.nt <= CW'(hsvrgb_pkg::FULL) - hsvrgb_pkg::div255(d_s2.nfs);
		end
	end

	// Scale q and t by value
	always_ff @(posedge clk) begin
		if (en.s4) begin
			d_s4.sector <= d_s3.sector;
			d_s4.val <= d_s3.val;
			d_s4.p <= d_s3.p;
			d_s4.qv <= d_s3.nq * d_s3.val;
			d_s4.tv <= d_s3.nt * d_s3.val;
		end
	end

	// Route v, p, q and t onto the channels
	always_comb begin
		q = hsvrgb_pkg::div255(d_s4.qv);
		t = hsvrgb_pkg::div255(d_s4.tv);
		unique case (d_s4.sector)
			hsvrgb_pkg::SEC_0: rgb_sel = '{red: d_s4.val, green: t, blue: d_s4.p};
			hsvrgb_pkg::SEC_1: rgb_sel = '{red: q, green: d_s4.val, blue: d_s4.p};
			hsvrgb_pkg::SEC_2: rgb_sel = '{red: d_s4.p, green: d_s4.val, blue: t};
			hsvrgb_pkg::SEC_3: rgb_sel = '{red: d_s4.p, green: q, blue: d_s4.val};
			hsvrgb_pkg::SEC_4: rgb_sel = '{red: t, green: d_s4.p, blue: d_s4.val};
			default:           rgb_sel = '{red: d_s4.val, green: d_s4.p, blue: q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			rgb_s5 <= rgb_sel;
		end
	end

	assign rgb = rgb_s5;

endmodule

`default_nettype wire

FILE: rtl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter, 8-bit integer arithmetic.
// Request channel hsv (hsv_valid/hsv_ready) carries hue 0..359 (values up to
// 511 wrap through the six sectors), saturation and brightness. Result
// channel rgb (rgb_valid/rgb_ready) carries red, green and blue.
// Each request yields exactly one result, in order.
// Pipeline: the result passes through the five-stage pipeline (hue split, two
// multiply stages, two divide-by-255 stages with the final channel select in
// the last one).
// Throughput: one request per cycle while rgb_ready stays high.
// Stall: each stage holds its data while the stage after it is full and
// stalled, so empty stages still fill while a result waits; hsv_ready
// drops only once all five stages are occupied and rgb_ready is low.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty
// and ready. No state is kept between pixels.
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hsv_valid,
	output logic                   hsv_ready,
	input  wire hsvrgb_pkg::hsv_t  hsv,
	output logic                   rgb_valid,
	input  wire logic              rgb_ready,
	output hsvrgb_pkg::rgb_t       rgb
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	hsvrgb_pkg::stage_en_t en;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en.s5 = !valid_s5 || rgb_ready;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign hsv_ready = en.s1;
	assign rgb_valid = valid_s5;

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= hsv_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	hsvrgb_core u_core (
		.clk (clk),
		.hsv (hsv),
		.en  (en),
		.rgb (rgb)
	);

endmodule

`default_nettype wire

FILE: rtl/hsvrgb_checker.sv
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsvrgb_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             hsv_valid,
	input wire logic             hsv_ready,
	input wire logic             rgb_valid,
	input wire logic             rgb_ready,
	input wire hsvrgb_pkg::rgb_t rgb
);

	// Edges needed to flush all five stages
	localparam int FLUSH_EDGES = 5;

	logic       rgb_stall;
	logic       req_fire;
	logic       flushed;
	logic [2:0] quiet_q;

	assign rgb_stall = rgb_valid && !rgb_ready;
	assign req_fire = hsv_valid && hsv_ready;
	assign flushed = (quiet_q == 3'(FLUSH_EDGES));

	// Count edges with no new request and a draining output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q <= '0;
		end else if (req_fire || !rgb_ready) begin
			quiet_q <= '0;
		end else if (!flushed) begin
			quiet_q <= quiet_q + 3'd1;
		end
	end

	// Hold a stalled result
	`HSVRGB_ASSERT_NEXT(a_rgb_valid_hold, rgb_stall, rgb_valid, "rgb_valid dropped while stalled")

	`HSVRGB_ASSERT_NEXT(a_rgb_data_hold, rgb_stall, $stable(rgb), "rgb changed while stalled")

	// Check that request ready drops only while the output is stalled (the pipeline is then full)
	`HSVRGB_ASSERT(a_ready_only_when_full, hsv_ready || rgb_stall, "hsv_ready low with room")

	// An idle request side with a draining output leaves the pipeline empty
	`HSVRGB_ASSERT(a_drain_empty, !flushed || !rgb_valid, "rgb_valid with pipeline empty")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int CW = hsvrgb_pkg::CH_W;
	localparam int HW = hsvrgb_pkg::HUE_W;
	localparam int RANDOM_COUNT = 1500;
	localparam int QUIET_TAIL = 200;
	localparam int MID_DRAIN_AT = 800;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hsv_valid = 1'b0;
	logic hsv_ready;
	hsvrgb_pkg::hsv_t hsv = '0;
	logic rgb_valid;
	logic rgb_ready = 1'b0;
	hsvrgb_pkg::rgb_t rgb;

	hsvrgb_pkg::hsv_t pending_pixels[$];
	hsvrgb_pkg::rgb_t expected_colors[$];
	int directed_count = 0;
	int sent_count = 0;
	int error_count = 0;
	int cycle_count = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int send_odds = 0;
	int stall_len = 0;
	int stall_odds = 0;
	hsvrgb_pkg::rgb_t want;

	hsv_to_rgb_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Compute the color that one pixel request must produce
	function automatic hsvrgb_pkg::rgb_t hsv_to_rgb_expect(hsvrgb_pkg::hsv_t px);
		int unsigned h, s, v, f, p, q, t, r, g, b;
		hsvrgb_pkg::sector_t sec;
		hsvrgb_pkg::rgb_t c;
		h = px.hue;
		s = px.saturation;
		v = px.brightness;
		f = (h % hsvrgb_pkg::SECTOR_DEG) * hsvrgb_pkg::FULL / hsvrgb_pkg::SECTOR_DEG;
		p = (hsvrgb_pkg::FULL - s) * v / hsvrgb_pkg::FULL;
		q = (hsvrgb_pkg::FULL - f * s / hsvrgb_pkg::FULL) * v / hsvrgb_pkg::FULL;
		t = (hsvrgb_pkg::FULL - (hsvrgb_pkg::FULL - f) * s / hsvrgb_pkg::FULL)
			* v / hsvrgb_pkg::FULL;
		// hue above 359 wraps back through the sectors
		sec = hsvrgb_pkg::sector_t'((h / hsvrgb_pkg::SECTOR_DEG) % hsvrgb_pkg::SECTORS);
		case (sec)
			hsvrgb_pkg::SEC_0: begin r = v; g = t; b = p; end
			hsvrgb_pkg::SEC_1: begin r = q; g = v; b = p; end
			hsvrgb_pkg::SEC_2: begin r = p; g = v; b = t; end
			hsvrgb_pkg::SEC_3: begin r = p; g = q; b = v; end
			hsvrgb_pkg::SEC_4: begin r = t; g = p; b = v; end
			default: begin r = v; g = p; b = q; end
		endcase
		c.red = CW'(r);
		c.green = CW'(g);
		c.blue = CW'(b);
		return c;
	endfunction

	task automatic add_pixel(input int h, input int s, input int v);
		hsvrgb_pkg::hsv_t px;
		px.hue = HW'(h);
		px.saturation = CW'(s);
		px.brightness = CW'(v);
		pending_pixels.push_back(px);
	endtask

	task automatic check_channel(input string name, input logic [CW-1:0] exp_val,
			input logic [CW-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			error_count++;
		end
	endtask

	// Drive pixel requests, with idle bursts and drain pauses
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count % 128 == 0)
				send_odds = 4 * $urandom_range(0, 3);
			if (hsv_valid && hsv_ready) begin
				expected_colors.push_back(hsv_to_rgb_expect(hsv));
				sent_count++;
			end
			if (!(hsv_valid && !hsv_ready)) begin
				if (send_gap == 0 && pending_pixels.size() >= QUIET_TAIL && send_odds != 0
						&& $urandom_range(1, send_odds) == 1)
					send_gap = $urandom_range(1, 9);
				if (send_gap > 0) begin
					send_gap--;
					hsv_valid <= 1'b0;
				end else if ((sent_count == directed_count || sent_count == MID_DRAIN_AT)
						&& expected_colors.size() != 0) begin
					// hold until every color in flight has come back
					hsv_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					hsv <= pending_pixels.pop_front();
					hsv_valid <= 1'b1;
				end else begin
					hsv_valid <= 1'b0;
				end
			end
		end
	end

	// Check returned colors and stall the result side at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (rgb_valid && rgb_ready) begin
				if (expected_colors.size() == 0) begin
					$error("color %h returned with no request pending", rgb);
					error_count++;
				end else begin
					want = expected_colors.pop_front();
					check_channel("red", want.red, rgb.red);
					check_channel("green", want.green, rgb.green);
					check_channel("blue", want.blue, rgb.blue);
				end
			end
			if (cycle_count % 128 == 0)
				stall_odds = 4 * $urandom_range(0, 3);
			if (stall_len == 0 && pending_pixels.size() >= QUIET_TAIL && stall_odds != 0
					&& $urandom_range(1, stall_odds) == 1)
				stall_len = $urandom_range(1, 9);
			if (stall_len > 0) begin
				stall_len--;
				rgb_ready <= 1'b0;
			end else begin
				rgb_ready <= 1'b1;
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int pick, h, s, v;
		// sector edges at full saturation and brightness
		add_pixel(0, 255, 255);
		add_pixel(59, 255, 255);
		add_pixel(60, 255, 255);
		add_pixel(119, 255, 255);
		add_pixel(120, 255, 255);
		add_pixel(179, 255, 255);
		add_pixel(180, 255, 255);
		add_pixel(239, 255, 255);
		add_pixel(240, 255, 255);
		add_pixel(299, 255, 255);
		add_pixel(300, 255, 255);
		add_pixel(359, 255, 255);
		// hue past 359 wraps into the first three sectors
		add_pixel(360, 255, 255);
		add_pixel(419, 200, 180);
		add_pixel(420, 128, 255);
		add_pixel(479, 255, 77);
		add_pixel(480, 1, 254);
		add_pixel(511, 255, 255);
		// gray, black and mid values
		add_pixel(200, 0, 255);
		add_pixel(90, 255, 0);
		add_pixel(0, 0, 0);
		add_pixel(511, 0, 0);
		add_pixel(30, 128, 200);
		add_pixel(330, 170, 85);
		directed_count = pending_pixels.size();

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			pick = $urandom_range(0, 9);
			h = $urandom_range(0, 359);
			s = $urandom_range(0, 255);
			v = $urandom_range(0, 255);
			if (pick == 0)
				h = $urandom_range(360, 511);
			else if (pick == 1)
				s = $urandom_range(0, 1) ? 255 : 0;
			else if (pick == 2)
				v = $urandom_range(0, 1) ? 255 : 0;
			add_pixel(h, s, v);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_pixels.size() != 0 || hsv_valid || expected_colors.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: hsv_to_rgb_converter.f
+incdir+rtl
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_core.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsvrgb_checker.sv
test/testbench.sv
